// ===== design/sqmm_pkg.sv =====
// ----------------------------------------------------------------------------
// sqmm_pkg
// Shared types and constants for the square matrix multiply block.
// ----------------------------------------------------------------------------
package sqmm_pkg;

  localparam int MAX_DIM_DEFAULT = 32;

  localparam int DIM_W     = 6;
  localparam int IDX_W     = 5;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int RESULT_W  = 40;
  localparam int OPCODE_W  = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 6'd10;

  // opcodes carried on the input tuser
  localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  // input tdata layout
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = RESULT_W;

  typedef logic signed [ELEM_W-1:0]   elem_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RESULT_W-1:0] result_t;

endpackage

// ===== design/square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Q8.8 square matrix multiply with element-wise load and per-element readout.
// ----------------------------------------------------------------------------
// Each input transaction writes one element of A, writes one element of B, or
// asks for one element R[row][col] of R = A x B; every transaction returns
// exactly one output transaction. Writes are acknowledged with tuser = 0 and a
// zero payload through the ST_FIN state and the output register, and the next
// transaction can be taken in the same cycle that the acknowledge appears. A
// result request walks the effective dimension n = min(dimension, MAX_DIM)
// element pairs through one shared 16x16 multiplier and a 40-bit accumulator,
// one pair per cycle, behind a registered read of the two element memories and
// a drain of the read/multiply/accumulate pipe; the result then passes through
// ST_FIN and the output register, and the next transaction can be taken in the
// same cycle that it appears. A stalled output register holds the block in ST_FIN.
// The input side is not ready while a transaction is in flight. Requests
// outside the effective dimension, or with dimension zero, return tuser = 1
// and a zero result by the same path as writes. Opcode 3 changes nothing and
// returns tuser = 0, zero payload. Writes outside MAX_DIM are dropped but
// acknowledged. Both memories power up undefined; reading an element that was
// never written gives an undefined result. The dimension register must only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
  parameter int MAX_DIM = sqmm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // dimension register
  input  logic                              cfg_we,
  input  logic [sqmm_pkg::DIM_W-1:0]        cfg_wdata,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sqmm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // row[4:0], col[9:5], element_value[25:10]
  input  logic [sqmm_pkg::OPCODE_W-1:0]     s_axis_tuser,  // opcode[1:0]
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sqmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // product_value[39:0]
  output logic [0:0]                        m_axis_tuser   // is_product[0]
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  logic [2:0] state;

  logic [sqmm_pkg::DIM_W-1:0] dimension;
  logic [sqmm_pkg::DIM_W-1:0] n_eff;

  // unpacked request fields
  logic [sqmm_pkg::IDX_W-1:0] in_row;
  logic [sqmm_pkg::IDX_W-1:0] in_col;
  sqmm_pkg::elem_t            in_value;
  logic                       in_accept;
  logic                       in_store;
  logic                       in_range;

  assign in_row    = s_axis_tdata[4:0];
  assign in_col    = s_axis_tdata[9:5];
  assign in_value  = s_axis_tdata[25:10];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // effective dimension saturates at MAX_DIM
  assign n_eff = ({1'b0, dimension} > 7'(MAX_DIM)) ? sqmm_pkg::DIM_W'(MAX_DIM) : dimension;

  assign in_store = (7'(in_row) < 7'(MAX_DIM)) && (7'(in_col) < 7'(MAX_DIM));
  assign in_range = ({1'b0, in_row} < n_eff) && ({1'b0, in_col} < n_eff);

  // request being worked on
  logic [sqmm_pkg::IDX_W-1:0] req_row;
  logic [sqmm_pkg::IDX_W-1:0] req_col;
  logic [sqmm_pkg::DIM_W-1:0] k;
  logic                       k_last;

  assign k_last = (k == n_eff - sqmm_pkg::DIM_W'(1));

  // pending result waiting for the output register
  logic            res_flag;
  sqmm_pkg::result_t acc;

  // element memories: A row-major, B column-major
  sqmm_pkg::elem_t mem_a [DEPTH];
  sqmm_pkg::elem_t mem_b [DEPTH];
  sqmm_pkg::elem_t a_rdata;
  sqmm_pkg::elem_t b_rdata;

  logic              a_we;
  logic              b_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [ADDR_W-1:0] b_waddr;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;

  assign a_we = in_accept && (s_axis_tuser == sqmm_pkg::OP_WRITE_A) && in_store;
  assign b_we = in_accept && (s_axis_tuser == sqmm_pkg::OP_WRITE_B) && in_store;

  assign a_waddr = ADDR_W'(32'(in_row) * 32'(MAX_DIM) + 32'(in_col));
  assign b_waddr = ADDR_W'(32'(in_col) * 32'(MAX_DIM) + 32'(in_row));
  assign a_raddr = ADDR_W'(32'(req_row) * 32'(MAX_DIM) + 32'(k));
  assign b_raddr = ADDR_W'(32'(req_col) * 32'(MAX_DIM) + 32'(k));

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_waddr] <= in_value;
    end
    a_rdata <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[b_waddr] <= in_value;
    end
    b_rdata <= mem_b[b_raddr];
  end

  // multiply-accumulate pipe: issue -> read data -> product -> accumulate
  logic            issue;
  logic            rd_v;
  logic            mul_v;
  sqmm_pkg::prod_t prod;

  assign issue = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_rdata * b_rdata;
  end

  // output register is free when empty or being drained this cycle
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= sqmm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      dimension <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            k <= '0;
            if ((s_axis_tuser == sqmm_pkg::OP_COMPUTE) && in_range) begin
              state <= ST_RUN;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_RUN: begin
          k <= k + sqmm_pkg::DIM_W'(1);
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !mul_v) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture and accumulator
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      req_row  <= in_row;
      req_col  <= in_col;
      res_flag <= (s_axis_tuser == sqmm_pkg::OP_COMPUTE);
      acc      <= '0;
    end else if (mul_v) begin
      acc <= acc + sqmm_pkg::result_t'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= acc;
      m_axis_tuser <= res_flag;
    end
  end

endmodule

// ===== design/sqmm_checker.sv =====
// ----------------------------------------------------------------------------
// sqmm_checker
// Port-level checks for the square matrix multiply block.
// ----------------------------------------------------------------------------
module sqmm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [sqmm_pkg::OPCODE_W-1:0]     s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sqmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);

  // no stale result after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // acknowledges carry a zero payload
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("write acknowledge with nonzero payload");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // a compute request never returns within the next cycle
  a_compute_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == sqmm_pkg::OP_COMPUTE
      |=> !(m_axis_tvalid && !$past(m_axis_tvalid)))
    else $error("result appeared too early");

endmodule

bind square_matrix_multiply sqmm_checker u_sqmm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
